FILE: hw/rtl/ssid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssid_pkg
// Shared types and constants of the sorted set insert block.
// ----------------------------------------------------------------------------
package ssid_pkg;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic {
    CMD_CLEAR  = 1'b0,
    CMD_INSERT = 1'b1
  } ssid_cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_CLEARED   = 2'd3
  } ssid_status_e;

  typedef struct packed {
    logic load;
    logic commit;
  } ssid_ctrl_t;

endpackage

FILE: hw/rtl/ssid_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssid_ctrl
// Sequencer: accepts a transaction, issues load and commit to the datapath
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module ssid_ctrl
  import ssid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ssid_ctrl_t ctrl_o
);

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ctrl_o       = '0;
    in_ready_o   = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.commit = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/ssid_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssid_datapath
// Chain of key cells: broadcast compare on load, one-step shift insert and
// result registers on commit.
// ----------------------------------------------------------------------------
module ssid_datapath
  import ssid_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssid_ctrl_t         ctrl_i,
  input  ssid_cmd_e          cmd_i,
  input  logic [KEY_W-1:0]   key_i,
  output ssid_status_e       status_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [COUNT_W-1:0] entry_count_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0]   cells_q [CAPACITY];
  logic [CAPACITY-1:0] lt_q, eq_q, valid, bound;
  logic [KEY_W-1:0]   key_q;
  ssid_cmd_e          cmd_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   pos;
  logic               full, dup, do_insert;
  ssid_status_e       status_q, status_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [COUNT_W-1:0] ecount_q;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = (count_q > CNT_W'(i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q <= key_i;
      cmd_q <= cmd_i;
      for (int i = 0; i < CAPACITY; i++) begin
        lt_q[i] <= valid[i] && (cells_q[i] < key_i);
        eq_q[i] <= valid[i] && (cells_q[i] == key_i);
      end
    end
  end

  always_comb begin
    bound[0] = !lt_q[0];
    for (int i = 1; i < CAPACITY; i++) begin
      bound[i] = !lt_q[i] && lt_q[i-1];
    end
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bound[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign full      = (count_q == CNT_W'(CAPACITY));
  assign dup       = |eq_q;
  assign do_insert = (cmd_q == CMD_INSERT) && !dup && !full;

  always_comb begin
    count_d  = count_q;
    status_d = ST_FULL;
    slot_d   = '0;
    if (cmd_q == CMD_CLEAR) begin
      count_d  = '0;
      status_d = ST_CLEARED;
    end else if (dup) begin
      status_d = ST_DUPLICATE;
      slot_d   = SLOT_W'(pos);
    end else if (!full) begin
      count_d  = count_q + CNT_W'(1);
      status_d = ST_INSERTED;
      slot_d   = SLOT_W'(pos);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && do_insert) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (bound[i]) begin
          cells_q[i] <= key_q;
        end else if (i > 0 && !lt_q[(i > 0) ? i - 1 : 0]) begin
          cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      ecount_q <= COUNT_W'(count_d);
    end
  end

  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign entry_count_o = ecount_q;

endmodule

FILE: hw/rtl/sorted_set_insert_dedup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_insert_dedup_top
// Sorted set of distinct keys with duplicate check, insert and clear.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY distinct 31-bit keys in ascending unsigned order in a
// chain of cells. In the accept cycle the key is compared against every cell
// at once and the outcome registered; in the commit state the chain shifts
// by one and the result register loads. The commit waits while a previous
// result is still unread, and the next transaction is accepted after it. An
// insert into a full set is rejected unless the key is already present, in
// which case a duplicate is reported. The slot output carries the low bits
// when CAPACITY exceeds 64, the count output when it exceeds 127.
// ----------------------------------------------------------------------------
module sorted_set_insert_dedup_top
  import ssid_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [30:0] key, [31] zero
  input  logic        s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [5:0] slot, [12:6] entry_count, [15:13] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  ssid_ctrl_t         ctrl;
  ssid_status_e       status;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] entry_count;

  ssid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  ssid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (ssid_cmd_e'(s_axis_tuser)),
    .key_i         (s_axis_tdata[KEY_W-1:0]),
    .status_o      (status),
    .slot_o        (slot),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {3'b000, entry_count, slot};
  assign m_axis_tuser = status;

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !ctrl.load))
    else $error("accept while transaction in flight");

  a_insert_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == ST_INSERTED) && (CAPACITY < 128)) |->
      (entry_count != '0))
    else $error("insert reported with empty set");

  a_cleared_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == ST_CLEARED)) |-> (entry_count == '0 && slot == '0))
    else $error("clear result not zero");

endmodule

FILE: tb/tb_sorted_set_insert_dedup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_set_insert_dedup_top
// Self-checking bench for the sorted set insert block.
// ----------------------------------------------------------------------------
// Sends clear and insert transactions over the input stream and checks every
// result against a queue-based model of the sorted key set. A short table
// covers the empty set, extreme keys, duplicates and clears. Random episodes
// follow: they fill the set to capacity and probe it while full, hammer narrow
// key windows for duplicates, and mix in stray clears. Both stream sides idle
// at random, and the output side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_sorted_set_insert_dedup_top;
  import ssid_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RAND_ITEMS   = 700;
  localparam int unsigned QUIET_AT     = 600;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_LEN     = 200;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_CYCLES   = 200000;
  localparam int unsigned DIR_ROWS     = 16;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    ssid_status_e       status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  typedef struct packed {
    ssid_cmd_e        cmd;
    logic [KEY_W-1:0] key;
    logic             typed;
    set_result_t      res;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [30:0] key, [31] zero
  logic        s_axis_tuser  = 1'b0; // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [5:0] slot, [12:6] entry_count, [15:13] zero
  logic [1:0]  m_axis_tuser;         // [1:0] status

  logic [KEY_W-1:0] held_keys[$];
  set_result_t      pending_results[$];
  dir_row_t         dir_rows[DIR_ROWS];
  int unsigned      status_tally[4] = '{default: 0};
  int unsigned      mismatches      = 0;
  int unsigned      cycles          = 0;
  int unsigned      peak_keys       = 0;
  int unsigned      rx_wait         = 0;
  logic             quiet           = 1'b0;
  logic             hold_req        = 1'b0;
  logic             hold_done       = 1'b0;

  sorted_set_insert_dedup_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic set_result_t next_set_result(ssid_cmd_e cmd, logic [KEY_W-1:0] key);
    set_result_t r;
    int          pos;
    r.status = ST_CLEARED;
    r.slot   = '0;
    r.count  = '0;
    if (cmd == CMD_CLEAR) begin
      held_keys.delete();
      return r;
    end
    pos = 0;
    foreach (held_keys[i]) if (held_keys[i] < key) pos++;
    r.count = COUNT_W'(held_keys.size());
    if (pos < held_keys.size() && held_keys[pos] == key) begin
      r.status = ST_DUPLICATE;
      r.slot   = SLOT_W'(pos);
    end else if (held_keys.size() >= CAPACITY) begin
      r.status = ST_FULL;
    end else begin
      held_keys.insert(pos, key);
      r.status = ST_INSERTED;
      r.slot   = SLOT_W'(pos);
      r.count  = COUNT_W'(held_keys.size());
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int unsigned dup_pct, logic [KEY_W-1:0] base,
                                                logic [KEY_W-1:0] span);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < dup_pct && held_keys.size() > 0)
      return held_keys[$urandom_range(0, held_keys.size() - 1)];
    if (roll >= 96)
      return roll[0] ? KEY_MAX : '0;
    return base + (KEY_W'($urandom) & span);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic send_item(ssid_cmd_e cmd, logic [KEY_W-1:0] key, logic typed,
                           set_result_t typed_res);
    set_result_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = next_set_result(cmd, key);
    pending_results.push_back(typed ? typed_res : predicted);
    status_tally[predicted.status]++;
    if (held_keys.size() > peak_keys) peak_keys = held_keys.size();
  endtask

  always @(posedge clk_i) begin
    if (rx_wait > 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done     <= 1'b1;
      rx_wait       <= HOLD_LEN - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rx_wait       <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d slot %0d count %0d",
                                m_axis_tuser, m_axis_tdata[SLOT_W-1:0],
                                m_axis_tdata[SLOT_W +: COUNT_W]));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser != want.status)
          note_mismatch($sformatf("status expected %0d, got %0d", want.status, m_axis_tuser));
        if (m_axis_tdata[SLOT_W-1:0] != want.slot)
          note_mismatch($sformatf("slot expected %0d, got %0d", want.slot,
                                  m_axis_tdata[SLOT_W-1:0]));
        if (m_axis_tdata[SLOT_W +: COUNT_W] != want.count)
          note_mismatch($sformatf("entry_count expected %0d, got %0d", want.count,
                                  m_axis_tdata[SLOT_W +: COUNT_W]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      episode;
    int unsigned      kind;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] span;
    dir_rows = '{
      '{CMD_CLEAR,  '0,                 1'b1, '{ST_CLEARED,   6'd0, 7'd0}},
      '{CMD_INSERT, KEY_MAX,            1'b1, '{ST_INSERTED,  6'd0, 7'd1}},
      '{CMD_INSERT, '0,                 1'b1, '{ST_INSERTED,  6'd0, 7'd2}},
      '{CMD_INSERT, '0,                 1'b1, '{ST_DUPLICATE, 6'd0, 7'd2}},
      '{CMD_INSERT, KEY_MAX,            1'b1, '{ST_DUPLICATE, 6'd1, 7'd2}},
      '{CMD_INSERT, 31'h2AAA_AAAA,      1'b0, '{ST_INSERTED,  6'd0, 7'd0}},
      '{CMD_INSERT, 31'h5555_5555,      1'b0, '{ST_INSERTED,  6'd0, 7'd0}},
      '{CMD_INSERT, 31'h0000_0001,      1'b0, '{ST_INSERTED,  6'd0, 7'd0}},
      '{CMD_INSERT, 31'h7FFF_FFFE,      1'b0, '{ST_INSERTED,  6'd0, 7'd0}},
      '{CMD_INSERT, 31'h5555_5555,      1'b0, '{ST_INSERTED,  6'd0, 7'd0}},
      '{CMD_INSERT, 31'h4000_0000,      1'b0, '{ST_INSERTED,  6'd0, 7'd0}},
      '{CMD_CLEAR,  KEY_MAX,            1'b1, '{ST_CLEARED,   6'd0, 7'd0}},
      '{CMD_CLEAR,  '0,                 1'b1, '{ST_CLEARED,   6'd0, 7'd0}},
      '{CMD_INSERT, 31'h1234_5678,      1'b1, '{ST_INSERTED,  6'd0, 7'd1}},
      '{CMD_INSERT, 31'h0000_FFFF,      1'b0, '{ST_INSERTED,  6'd0, 7'd0}},
      '{CMD_CLEAR,  31'h3C3C_3C3C,      1'b1, '{ST_CLEARED,   6'd0, 7'd0}}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);

    sent    = 0;
    episode = 0;
    while (sent < RAND_ITEMS) begin
      kind = (episode == 0) ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 4) != 0) begin
        send_item(CMD_CLEAR, KEY_W'($urandom), 1'b0, '0);
        sent++;
      end
      if (kind < 3) begin
        while (held_keys.size() < CAPACITY) begin
          send_item(CMD_INSERT, pick_key(15, '0, '1), 1'b0, '0);
          sent++;
        end
        repeat ($urandom_range(2, 8)) begin
          send_item(CMD_INSERT, pick_key(50, '0, '1), 1'b0, '0);
          sent++;
        end
      end else if (kind < 7) begin
        base = KEY_W'($urandom);
        span = KEY_W'((1 << $urandom_range(3, 7)) - 1);
        repeat ($urandom_range(5, 40)) begin
          send_item(CMD_INSERT, pick_key(25, base, span), 1'b0, '0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 15)) begin
          send_item(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_INSERT,
                    pick_key(20, '0, '1), 1'b0, '0);
          sent++;
        end
      end
      episode++;
      if (sent >= HOLD_AT) hold_req <= 1'b1;
      if (sent >= QUIET_AT) quiet <= 1'b1;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d transactions in %0d episodes: %0d inserted, %0d duplicate, %0d full, %0d clear",
             sent + DIR_ROWS, episode, status_tally[ST_INSERTED], status_tally[ST_DUPLICATE],
             status_tally[ST_FULL], status_tally[ST_CLEARED]);
    $display("largest set held %0d of %0d keys, %0d mismatches", peak_keys, CAPACITY,
             mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
